FILE: rtl/point_bend_inflate_twist_taper_warp_defines.svh
// Assertion macros for the warp RTL.
`ifndef POINT_BEND_INFLATE_TWIST_TAPER_WARP_DEFINES_SVH
`define POINT_BEND_INFLATE_TWIST_TAPER_WARP_DEFINES_SVH
`ifndef SYNTHESIS
`define PBITW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PBITW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PBITW_ASSERT(lbl, prop, msg)
`define PBITW_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: rtl/pbitw_pkg.sv
package pbitw_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [31:0] DEG_TO_PHASE = 32'd11930465;
  localparam logic [29:0] RADIUS_K = 30'd961263670;
  localparam int TAPER_FLOOR = 3277;
  localparam longint ONE_Q30 = 64'sd1 <<< 30;

  localparam logic [31:0] SC1 = 32'd1686629713;
  localparam logic [31:0] SC3 = 32'd693598668;
  localparam logic [31:0] SC5 = 32'd85569305;
  localparam logic [31:0] SC7 = 32'd5026995;
  localparam logic [31:0] SC9 = 32'd172272;

  typedef enum logic [2:0] {
    CFG_BOUNDS_LEFT     = 3'd0,
    CFG_BOUNDS_WIDTH    = 3'd1,
    CFG_BOUNDS_CENTER_Y = 3'd2,
    CFG_INFLATE_ORIGIN  = 3'd3,
    CFG_BEND_ANGLE      = 3'd4,
    CFG_INFLATE_FACTOR  = 3'd5,
    CFG_TWIST_ANGLE     = 3'd6,
    CFG_TAPER_FACTOR    = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    RD_MUL  = 3'b001,
    RD_DIV  = 3'b010,
    RD_DONE = 3'b100
  } rd_state_t;

endpackage

FILE: rtl/pbitw_mul.sv
module pbitw_mul #(
  parameter int SH = 30
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [63:0] a,
  input  logic signed [33:0] b,
  output logic signed [63:0] p
);
  localparam int UP = 32 - SH;
  localparam logic [66:0] LIM = 67'd1 << 60;
  localparam logic [66:0] PHI_MAX = 67'd1 << (60 - UP);
  localparam logic [66:0] HALF = 67'd1 << (SH - 1);

  logic [63:0] ua;
  logic [32:0] ub;
  logic        neg_r;
  logic [64:0] phi_r;
  logic [64:0] plo_r;
  logic [66:0] sum;
  logic [66:0] mag;

  always_comb begin
    ua = a[63] ? 64'(-a) : 64'(a);
    ub = b[33] ? 33'(-b) : 33'(b);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_r <= a[63] ^ b[33];
      phi_r <= 65'(ua[63:32]) * 65'(ub);
      plo_r <= 65'(ua[31:0]) * 65'(ub);
    end
  end

  always_comb begin
    sum = (67'(phi_r) << UP) + ((67'(plo_r) + HALF) >> SH);
    if (67'(phi_r) > PHI_MAX) begin
      mag = LIM;
    end else if (sum > LIM) begin
      mag = LIM;
    end else begin
      mag = sum;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p <= neg_r ? -$signed(64'(mag)) : $signed(64'(mag));
    end
  end

endmodule

FILE: rtl/pbitw_sin.sv
module pbitw_sin (
  input  logic               clk,
  input  logic               en,
  input  logic [31:0]        phase,
  output logic signed [31:0] value
);
  import pbitw_pkg::*;

  logic [30:0] z_r  [1:6];
  logic        n_r  [1:6];
  logic [30:0] z2_r [2:5];
  logic [31:0] r_r  [3:6];
  logic [30:0] z_in;
  logic [63:0] m2;
  logic [63:0] m3;
  logic [63:0] m4;
  logic [63:0] m5;
  logic [63:0] m6;
  logic [63:0] m7;
  logic [63:0] res;

  always_comb begin
    z_in = phase[30] ? (31'd1 << 30) - 31'(phase[29:0]) : 31'(phase[29:0]);
    m2 = 64'(z_r[1]) * 64'(z_r[1]);
    m3 = 64'(SC9) * 64'(z2_r[2]);
    m4 = 64'(r_r[3]) * 64'(z2_r[3]);
    m5 = 64'(r_r[4]) * 64'(z2_r[4]);
    m6 = 64'(r_r[5]) * 64'(z2_r[5]);
    m7 = (64'(z_r[6]) * 64'(r_r[6])) >> 30;
    res = (m7 > 64'(ONE_Q30)) ? 64'(ONE_Q30) : m7;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z_r[1] <= z_in;
      n_r[1] <= phase[31];
      for (int k = 2; k <= 6; k++) begin
        z_r[k] <= z_r[k-1];
        n_r[k] <= n_r[k-1];
      end
      z2_r[2] <= 31'(m2 >> 30);
      for (int k = 3; k <= 5; k++) begin
        z2_r[k] <= z2_r[k-1];
      end
      r_r[3] <= SC7 - 32'(m3 >> 30);
      r_r[4] <= SC5 - 32'(m4 >> 30);
      r_r[5] <= SC3 - 32'(m5 >> 30);
      r_r[6] <= SC1 - 32'(m6 >> 30);
      value  <= n_r[6] ? -$signed(32'(res)) : $signed(32'(res));
    end
  end

endmodule

FILE: rtl/point_bend_inflate_twist_taper_warp.sv
// Throughput: one request per cycle; a stalled output freezes the whole pipeline.
// After reset and after every configuration write the bend radius divider runs
// (one quotient bit per cycle), and no request is taken meanwhile.
// Reset is synchronous and active low; it empties the pipeline and loads the
// register defaults (bounds width 1.0, all others zero).
`include "point_bend_inflate_twist_taper_warp_defines.svh"

module point_bend_inflate_twist_taper_warp #(
  parameter int COORD_WIDTH = pbitw_pkg::COORD_WIDTH_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  // point_x, point_y
  input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]      in_tdata,
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  // warped_x, warped_y
  output logic [((2*COORD_WIDTH+7)/8)*8-1:0]      out_tdata,
  input  logic                                    cfg_wr_en,
  input  logic [pbitw_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [pbitw_pkg::CFG_DATA_W-1:0]        cfg_wdata
);
  import pbitw_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int TW = ((2*CW+7)/8)*8;
  localparam int L = 42;
  localparam logic signed [63:0] CMAX = (64'sd1 <<< (CW-1)) - 64'sd1;
  localparam logic signed [63:0] CMIN = -(64'sd1 <<< (CW-1));

  function automatic logic signed [CW-1:0] sat_c(input logic signed [63:0] v);
    if (v > CMAX) return CMAX[CW-1:0];
    if (v < CMIN) return CMIN[CW-1:0];
    return v[CW-1:0];
  endfunction

  // Configuration registers.
  logic signed [31:0] left_r;
  logic [30:0]        width_r;
  logic signed [31:0] cy_r;
  logic [63:0]        origin_r;
  logic signed [17:0] bend_r;
  logic signed [15:0] infl_r;
  logic signed [17:0] twist_r;
  logic signed [15:0] taper_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r   <= '0;
      width_r  <= 31'd65536;
      cy_r     <= '0;
      origin_r <= '0;
      bend_r   <= '0;
      infl_r   <= '0;
      twist_r  <= '0;
      taper_r  <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_BOUNDS_LEFT:     left_r   <= cfg_wdata[31:0];
        CFG_BOUNDS_WIDTH:    width_r  <= cfg_wdata[30:0];
        CFG_BOUNDS_CENTER_Y: cy_r     <= cfg_wdata[31:0];
        CFG_INFLATE_ORIGIN:  origin_r <= cfg_wdata;
        CFG_BEND_ANGLE:      bend_r   <= cfg_wdata[17:0];
        CFG_INFLATE_FACTOR:  infl_r   <= cfg_wdata[15:0];
        CFG_TWIST_ANGLE:     twist_r  <= cfg_wdata[17:0];
        CFG_TAPER_FACTOR:    taper_r  <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  logic signed [63:0] cx;
  logic signed [63:0] cy;
  logic signed [63:0] ox;
  logic signed [63:0] oy;
  logic [17:0]        bend_mag;
  logic signed [15:0] infl_eff;

  always_comb begin
    cx = 64'(left_r) + $signed(64'(width_r >> 1));
    cy = 64'(cy_r);
    ox = 64'($signed(origin_r[63:32]));
    oy = 64'($signed(origin_r[31:0]));
    bend_mag = bend_r[17] ? 18'(-bend_r) : 18'(bend_r);
    infl_eff = (infl_r == 16'sd0) ? 16'sd4096 : infl_r;
  end

  // Bend radius: width * K / (|bend| << 16), one quotient bit per cycle.
  rd_state_t   rd_state_r;
  logic [60:0] rnum_r;
  logic [33:0] rrem_r;
  logic [45:0] rq_r;
  logic [5:0]  rcnt_r;
  logic [33:0] rden;
  logic [34:0] rtmp;
  logic        rbit;

  always_comb begin
    rden = {bend_mag, 16'b0};
    rtmp = {rrem_r, rnum_r[60]};
    rbit = (rtmp >= {1'b0, rden});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_state_r <= RD_MUL;
      rcnt_r     <= '0;
    end else if (cfg_wr_en) begin
      rd_state_r <= RD_MUL;
    end else begin
      case (rd_state_r)
        RD_MUL: begin
          rnum_r     <= 61'(width_r) * 61'(RADIUS_K);
          rrem_r     <= '0;
          rq_r       <= '0;
          rcnt_r     <= 6'd60;
          rd_state_r <= RD_DIV;
        end
        RD_DIV: begin
          rrem_r <= rbit ? 34'(rtmp - {1'b0, rden}) : rtmp[33:0];
          rnum_r <= {rnum_r[59:0], 1'b0};
          rq_r   <= {rq_r[44:0], rbit};
          rcnt_r <= rcnt_r - 6'd1;
          if (rcnt_r == 6'd0) begin
            rd_state_r <= RD_DONE;
          end
        end
        RD_DONE: ;
        default: rd_state_r <= RD_MUL;
      endcase
    end
  end

  // Pipeline control.
  logic         en;
  logic         acc;
  logic [L-1:0] vld_r;

  assign en         = !vld_r[L-1] || out_tready;
  assign in_tready  = en && (rd_state_r == RD_DONE);
  assign acc        = in_tvalid && in_tready;
  assign out_tvalid = vld_r[L-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[L-2:0], acc};
    end
  end

  // Stage 0 and the normalizing divider, stages 1 to 16.
  logic signed [CW-1:0] px_in;
  logic signed [CW-1:0] py_in;
  logic signed [63:0]   d_in;
  logic                 dle_in;
  logic                 dge_in;

  logic signed [CW-1:0] px_r  [0:28];
  logic signed [CW-1:0] py_r  [0:28];
  logic                 dle_r [0:16];
  logic                 dge_r [0:16];
  logic [30:0]          rem_r [0:16];
  logic [15:0]          q_r   [0:16];
  logic [30:0]          rem_nxt [1:16];
  logic [15:0]          q_nxt   [1:16];
  logic [31:0]          dtmp;

  always_comb begin
    px_in  = in_tdata[CW-1:0];
    py_in  = in_tdata[2*CW-1:CW];
    d_in   = 64'(px_in) - 64'(left_r);
    dle_in = (d_in <= 64'sd0);
    dge_in = (d_in >= $signed(64'(width_r)));
    for (int k = 1; k <= 16; k++) begin
      dtmp = {rem_r[k-1], 1'b0};
      if (dtmp >= {1'b0, width_r}) begin
        rem_nxt[k] = 31'(dtmp - {1'b0, width_r});
        q_nxt[k]   = {q_r[k-1][14:0], 1'b1};
      end else begin
        rem_nxt[k] = dtmp[30:0];
        q_nxt[k]   = {q_r[k-1][14:0], 1'b0};
      end
    end
  end

  // Stage 17 to 19: centered x, taper scale and phases.
  logic [16:0]          xn_c;
  logic signed [17:0]   xc_c;
  logic signed [17:0]   xc17_r;
  logic signed [63:0]   yrel_r [17:26];
  logic signed [36:0]   pb18_r;
  logic signed [35:0]   pt18_r;
  logic [20:0]          sc_r   [18:38];
  logic signed [39:0]   tt;
  logic [39:0]          tt_mag;
  logic signed [39:0]   tt_rnd;
  logic signed [39:0]   sc_c;
  logic [63:0]          phb_t;
  logic [63:0]          pht_t;
  logic [31:0]          phb19_r;
  logic [31:0]          pht19_r;

  always_comb begin
    if (width_r == 31'd0) begin
      xn_c = 17'd32768;
    end else if (dle_r[16]) begin
      xn_c = 17'd0;
    end else if (dge_r[16]) begin
      xn_c = 17'd65536;
    end else begin
      xn_c = {1'b0, q_r[16]};
    end
    xc_c   = $signed({1'b0, xn_c}) - 18'sd32768;
    tt     = 40'(taper_r) * 40'(xc17_r) * 40'sd2;
    tt_mag = tt[39] ? 40'(-tt) : 40'(tt);
    tt_mag = (tt_mag + 40'd2048) >> 12;
    tt_rnd = tt[39] ? -$signed(tt_mag) : $signed(tt_mag);
    sc_c   = 40'sd65536 + tt_rnd;
    if (sc_c < 40'(TAPER_FLOOR)) begin
      sc_c = 40'(TAPER_FLOOR);
    end
    phb_t = 64'(pb18_r) * 64'(DEG_TO_PHASE) + (64'd1 << 23);
    pht_t = 64'(pt18_r) * 64'(DEG_TO_PHASE) + (64'd1 << 23);
  end

  logic signed [31:0] s_bs;
  logic signed [31:0] s_bc;
  logic signed [31:0] s_ts;
  logic signed [31:0] s_tc;

  pbitw_sin u_sin_bs (.clk(clk), .en(en), .phase(phb19_r), .value(s_bs));
  pbitw_sin u_sin_bc (.clk(clk), .en(en), .phase(phb19_r + 32'h4000_0000), .value(s_bc));
  pbitw_sin u_sin_ts (.clk(clk), .en(en), .phase(pht19_r), .value(s_ts));
  pbitw_sin u_sin_tc (.clk(clk), .en(en), .phase(pht19_r + 32'h4000_0000), .value(s_tc));

  // Bend products, aligned with stage 26, results at stage 28.
  logic signed [63:0] m_arcx;
  logic signed [63:0] m_arcy;
  logic signed [63:0] m_nx;
  logic signed [63:0] m_ny;
  logic signed [63:0] radius;

  assign radius = $signed(64'(rq_r));

  pbitw_mul #(.SH(30)) u_mul_arcx (.clk(clk), .en(en), .a(radius), .b(34'(s_bs)), .p(m_arcx));
  pbitw_mul #(.SH(30)) u_mul_arcy (.clk(clk), .en(en), .a(radius),
                                   .b(34'(ONE_Q30) - 34'(s_bc)), .p(m_arcy));
  pbitw_mul #(.SH(30)) u_mul_nx (.clk(clk), .en(en), .a(yrel_r[26]), .b(34'(s_bs)), .p(m_nx));
  pbitw_mul #(.SH(30)) u_mul_ny (.clk(clk), .en(en), .a(yrel_r[26]), .b(34'(s_bc)), .p(m_ny));

  logic signed [CW-1:0] wx29_r;
  logic signed [CW-1:0] wy29_r;
  logic signed [63:0]   arcy_s;
  logic signed [63:0]   nx_s;

  always_comb begin
    arcy_s = bend_r[17] ? -m_arcy : m_arcy;
    nx_s   = bend_r[17] ? -m_nx : m_nx;
  end

  // Inflate: differences at 30, products at 32, result at 33.
  logic signed [63:0]   dix30_r;
  logic signed [63:0]   diy30_r;
  logic signed [CW-1:0] wix_r [30:32];
  logic signed [CW-1:0] wiy_r [30:32];
  logic signed [63:0]   m_ix;
  logic signed [63:0]   m_iy;
  logic signed [CW-1:0] wx33_r;
  logic signed [CW-1:0] wy33_r;

  pbitw_mul #(.SH(12)) u_mul_ix (.clk(clk), .en(en), .a(dix30_r), .b(34'(infl_eff)), .p(m_ix));
  pbitw_mul #(.SH(12)) u_mul_iy (.clk(clk), .en(en), .a(diy30_r), .b(34'(infl_eff)), .p(m_iy));

  // Twist: differences at 34, products at 36, result at 37.
  logic signed [31:0]   tsd_r [27:34];
  logic signed [31:0]   tcd_r [27:34];
  logic signed [63:0]   dx34_r;
  logic signed [63:0]   dy34_r;
  logic signed [CW-1:0] wtx_r [34:36];
  logic signed [CW-1:0] wty_r [34:36];
  logic signed [63:0]   m_dxc;
  logic signed [63:0]   m_dys;
  logic signed [63:0]   m_dxs;
  logic signed [63:0]   m_dyc;
  logic signed [CW-1:0] wx37_r;
  logic signed [CW-1:0] wy37_r;

  pbitw_mul #(.SH(30)) u_mul_dxc (.clk(clk), .en(en), .a(dx34_r), .b(34'(tcd_r[34])), .p(m_dxc));
  pbitw_mul #(.SH(30)) u_mul_dys (.clk(clk), .en(en), .a(dy34_r), .b(34'(tsd_r[34])), .p(m_dys));
  pbitw_mul #(.SH(30)) u_mul_dxs (.clk(clk), .en(en), .a(dx34_r), .b(34'(tsd_r[34])), .p(m_dxs));
  pbitw_mul #(.SH(30)) u_mul_dyc (.clk(clk), .en(en), .a(dy34_r), .b(34'(tcd_r[34])), .p(m_dyc));

  // Taper: difference at 38, product at 40, output register at 41.
  logic signed [63:0]   dty38_r;
  logic signed [CW-1:0] wpx_r [38:40];
  logic signed [CW-1:0] wpy_r [38:40];
  logic signed [63:0]   m_tp;
  logic signed [CW-1:0] outx_r;
  logic signed [CW-1:0] outy_r;

  pbitw_mul #(.SH(16)) u_mul_tp (.clk(clk), .en(en), .a(dty38_r),
                                 .b($signed(34'(sc_r[38]))), .p(m_tp));

  always_ff @(posedge clk) begin
    if (en) begin
      px_r[0]  <= px_in;
      py_r[0]  <= py_in;
      dle_r[0] <= dle_in;
      dge_r[0] <= dge_in;
      rem_r[0] <= (!dle_in && !dge_in) ? d_in[30:0] : 31'd0;
      q_r[0]   <= '0;
      for (int k = 1; k <= 28; k++) begin
        px_r[k] <= px_r[k-1];
        py_r[k] <= py_r[k-1];
      end
      for (int k = 1; k <= 16; k++) begin
        dle_r[k] <= dle_r[k-1];
        dge_r[k] <= dge_r[k-1];
        rem_r[k] <= rem_nxt[k];
        q_r[k]   <= q_nxt[k];
      end

      xc17_r     <= xc_c;
      yrel_r[17] <= 64'(py_r[16]) - cy;
      for (int k = 18; k <= 26; k++) begin
        yrel_r[k] <= yrel_r[k-1];
      end
      pb18_r   <= $signed({19'd0, bend_mag}) * 37'(xc17_r);
      pt18_r   <= 36'(twist_r) * 36'(xc17_r);
      sc_r[18] <= sc_c[20:0];
      for (int k = 19; k <= 38; k++) begin
        sc_r[k] <= sc_r[k-1];
      end
      phb19_r <= phb_t[55:24];
      pht19_r <= pht_t[55:24];

      tsd_r[27] <= s_ts;
      tcd_r[27] <= s_tc;
      for (int k = 28; k <= 34; k++) begin
        tsd_r[k] <= tsd_r[k-1];
        tcd_r[k] <= tcd_r[k-1];
      end

      if (bend_r != 18'sd0) begin
        wx29_r <= sat_c(cx + m_arcx - nx_s);
        wy29_r <= sat_c(cy + arcy_s + m_ny);
      end else begin
        wx29_r <= px_r[28];
        wy29_r <= py_r[28];
      end

      dix30_r  <= 64'(wx29_r) - ox;
      diy30_r  <= 64'(wy29_r) - oy;
      wix_r[30] <= wx29_r;
      wiy_r[30] <= wy29_r;
      for (int k = 31; k <= 32; k++) begin
        wix_r[k] <= wix_r[k-1];
        wiy_r[k] <= wiy_r[k-1];
      end
      if (infl_eff != 16'sd4096) begin
        wx33_r <= sat_c(ox + m_ix);
        wy33_r <= sat_c(oy + m_iy);
      end else begin
        wx33_r <= wix_r[32];
        wy33_r <= wiy_r[32];
      end

      dx34_r    <= 64'(wx33_r) - cx;
      dy34_r    <= 64'(wy33_r) - cy;
      wtx_r[34] <= wx33_r;
      wty_r[34] <= wy33_r;
      for (int k = 35; k <= 36; k++) begin
        wtx_r[k] <= wtx_r[k-1];
        wty_r[k] <= wty_r[k-1];
      end
      if (twist_r != 18'sd0) begin
        wx37_r <= sat_c(cx + m_dxc - m_dys);
        wy37_r <= sat_c(cy + m_dxs + m_dyc);
      end else begin
        wx37_r <= wtx_r[36];
        wy37_r <= wty_r[36];
      end

      dty38_r   <= 64'(wy37_r) - cy;
      wpx_r[38] <= wx37_r;
      wpy_r[38] <= wy37_r;
      for (int k = 39; k <= 40; k++) begin
        wpx_r[k] <= wpx_r[k-1];
        wpy_r[k] <= wpy_r[k-1];
      end
      outx_r <= wpx_r[40];
      outy_r <= (taper_r != 16'sd0) ? sat_c(cy + m_tp) : wpy_r[40];
    end
  end

  assign out_tdata = TW'({outy_r, outx_r});

  `PBITW_ASSERT(a_cfg_holds_input, cfg_wr_en |=> !in_tready, "request taken while radius stale")
  `PBITW_ASSERT_ALWAYS(a_rst_clears_out, !rst_n |=> !out_tvalid, "result valid after reset")
  `PBITW_ASSERT(a_last_stage_moves, (en && vld_r[L-2]) |=> out_tvalid, "result lost at output")

endmodule
